// File: rtl/c_like_source_lexer_macros.svh
// assertion macros shared by the lexer rtl
`ifndef C_LIKE_SOURCE_LEXER_MACROS_SVH
`define C_LIKE_SOURCE_LEXER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define CLSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CLSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CLSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/clsl_pkg.sv
// types, constants and lookup functions of the source lexer
`timescale 1ns / 1ps
`default_nettype none
package clsl_pkg;

  localparam int unsigned PositionBits = 24;
  localparam int unsigned LineBits     = 20;
  localparam int unsigned KindBits     = 6;
  localparam int unsigned KwCount      = 17;
  localparam int unsigned KwMaxLen     = 6;
  localparam int unsigned KwBits       = KwMaxLen * 8;
  localparam int unsigned KwIdxBits    = $clog2(KwCount);
  localparam int unsigned KwLenBits    = $clog2(KwMaxLen + 1);
  localparam int unsigned InQDepth     = 2;
  localparam int unsigned OutQDepth    = 4;

  // token kinds
  localparam logic [KindBits-1:0] KindId    = 6'd17;
  localparam logic [KindBits-1:0] KindNum   = 6'd18;
  localparam logic [KindBits-1:0] KindAnd   = 6'd40;
  localparam logic [KindBits-1:0] KindOr    = 6'd41;
  localparam logic [KindBits-1:0] KindInc   = 6'd42;
  localparam logic [KindBits-1:0] KindDec   = 6'd43;
  localparam logic [KindBits-1:0] KindEnd   = 6'd44;

  // character classes seen by the scanner
  typedef enum logic [3:0] {
    ClsSpace,
    ClsNewline,
    ClsAlpha,
    ClsDigit,
    ClsSlash,
    ClsAmp,
    ClsBar,
    ClsPlus,
    ClsMinus,
    ClsStar,
    ClsDot,
    ClsOther
  } clsl_cls_e;

  // scanner state
  typedef enum logic [10:0] {
    ModeIdle      = 11'b000_0000_0001,
    ModeWord      = 11'b000_0000_0010,
    ModeNum       = 11'b000_0000_0100,
    ModeSlash     = 11'b000_0000_1000,
    ModeAmp       = 11'b000_0001_0000,
    ModeBar       = 11'b000_0010_0000,
    ModePlus      = 11'b000_0100_0000,
    ModeMinus     = 11'b000_1000_0000,
    ModeLineCom   = 11'b001_0000_0000,
    ModeBlock     = 11'b010_0000_0000,
    ModeBlockStar = 11'b100_0000_0000
  } clsl_mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } clsl_in_t;

  typedef struct packed {
    logic [KindBits-1:0]     token_kind;
    logic [LineBits-1:0]     token_line;
    logic [PositionBits-1:0] token_start;
    logic [PositionBits-1:0] token_length;
    logic [7:0]              token_char;
    logic                    last_of_run;
  } clsl_out_t;

  // classified byte between front and back
  typedef struct packed {
    logic [7:0]          char_code;
    logic                end_of_text;
    clsl_cls_e           cls;
    logic [KindBits-1:0] pkind;
  } clsl_item_t;

  // up to two results written by the scanner in one cycle
  typedef struct packed {
    logic [1:0]            en;
    clsl_out_t [1:0]       beat;
  } clsl_push_t;

  function automatic clsl_cls_e classify(logic [7:0] c);
    clsl_cls_e r;
    priority if (c == 8'h0A) r = ClsNewline;
    else if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D) r = ClsSpace;
    else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") r = ClsAlpha;
    else if (c >= "0" && c <= "9") r = ClsDigit;
    else if (c == "/") r = ClsSlash;
    else if (c == "&") r = ClsAmp;
    else if (c == "|") r = ClsBar;
    else if (c == "+") r = ClsPlus;
    else if (c == "-") r = ClsMinus;
    else if (c == "*") r = ClsStar;
    else if (c == ".") r = ClsDot;
    else r = ClsOther;
    return r;
  endfunction

  // single-character token kind, end kind for anything unknown
  function automatic logic [KindBits-1:0] punct_kind(logic [7:0] c);
    logic [KindBits-1:0] k;
    unique case (c)
      "{":     k = 6'd19;
      "}":     k = 6'd20;
      "(":     k = 6'd21;
      ")":     k = 6'd22;
      "[":     k = 6'd23;
      "]":     k = 6'd24;
      ";":     k = 6'd25;
      ",":     k = 6'd26;
      ".":     k = 6'd27;
      "=":     k = 6'd28;
      "<":     k = 6'd29;
      ">":     k = 6'd30;
      "?":     k = 6'd31;
      ":":     k = 6'd32;
      "!":     k = 6'd33;
      "+":     k = 6'd34;
      "-":     k = 6'd35;
      "*":     k = 6'd36;
      "/":     k = 6'd37;
      "%":     k = 6'd38;
      "&":     k = 6'd39;
      default: k = KindEnd;
    endcase
    return k;
  endfunction

  // keyword text, first character in the top byte, zero padded
  function automatic logic [KwBits-1:0] kw_text(logic [KwIdxBits-1:0] k);
    logic [KwBits-1:0] t;
    unique case (k)
      5'd0:    t = {"if", 32'h0};
      5'd1:    t = {"else", 16'h0};
      5'd2:    t = {"int", 24'h0};
      5'd3:    t = {"float", 8'h0};
      5'd4:    t = {"long", 16'h0};
      5'd5:    t = {"bool", 16'h0};
      5'd6:    t = {"void", 16'h0};
      5'd7:    t = {"const", 8'h0};
      5'd8:    t = {"enum", 16'h0};
      5'd9:    t = "struct";
      5'd10:   t = "return";
      5'd11:   t = {"while", 8'h0};
      5'd12:   t = {"do", 32'h0};
      5'd13:   t = {"for", 24'h0};
      5'd14:   t = {"pile", 16'h0};
      5'd15:   t = {"true", 16'h0};
      5'd16:   t = {"false", 8'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [KwLenBits-1:0] kw_len(logic [KwIdxBits-1:0] k);
    logic [KwLenBits-1:0] n;
    unique case (k)
      5'd0, 5'd12:                         n = 3'd2;
      5'd2, 5'd13:                         n = 3'd3;
      5'd1, 5'd4, 5'd5, 5'd6, 5'd8,
      5'd14, 5'd15:                        n = 3'd4;
      5'd3, 5'd7, 5'd11, 5'd16:            n = 3'd5;
      5'd9, 5'd10:                         n = 3'd6;
      default:                             n = 3'd0;
    endcase
    return n;
  endfunction

  // character p of keyword k
  function automatic logic [7:0] kw_char(logic [KwIdxBits-1:0] k, logic [KwLenBits-1:0] p);
    logic [KwBits-1:0] t;
    t = kw_text(k);
    return t[(KwMaxLen - 1 - int'(p)) * 8 +: 8];
  endfunction

endpackage
`default_nettype wire

// File: rtl/clsl_front.sv
// front end: accepts source bytes, classifies them and queues them
`timescale 1ns / 1ps
`default_nettype none
module clsl_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  clsl_pkg::clsl_in_t     in_i,
  output logic                   item_valid_o,
  input  wire                    item_ready_i,
  output clsl_pkg::clsl_item_t   item_o
);
  import clsl_pkg::*;

  localparam int unsigned PtrW = $clog2(InQDepth);
  localparam int unsigned CntW = $clog2(InQDepth + 1);

  clsl_item_t            entry_q [InQDepth];
  logic [PtrW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  push, pop;
  clsl_item_t            cls_item;

  // classify the incoming beat
  always_comb begin
    cls_item.char_code   = in_i.char_code;
    cls_item.end_of_text = in_i.end_of_text;
    cls_item.cls         = classify(in_i.char_code);
    cls_item.pkind       = punct_kind(in_i.char_code);
  end

  assign in_ready_o   = (cnt_q != CntW'(InQDepth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = entry_q[rptr_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = item_valid_o & item_ready_i;

  // queue pointers and fill
  always_comb begin
    wptr_d = push ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d = pop ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d  = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= cls_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/clsl_scan.sv
// back end: token scanner state machine, emits up to two results per byte
`timescale 1ns / 1ps
`default_nettype none
module clsl_scan (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    item_valid_i,
  output logic                   item_ready_o,
  input  clsl_pkg::clsl_item_t   item_i,
  input  wire                    room_i,
  output clsl_pkg::clsl_push_t   push_o
);
  import clsl_pkg::*;

  clsl_mode_e              mode_q, mode_d;
  logic [LineBits-1:0]     line_q, line_d, line_inc;
  logic [PositionBits-1:0] pos_q, pos_d, pos_inc;
  logic [PositionBits-1:0] begin_q, begin_d;
  logic [PositionBits-1:0] len_q, len_d, len_inc;
  logic [7:0]              first_q, first_d;
  logic [KindBits-1:0]     fkind_q, fkind_d;
  logic [KwCount-1:0]      cand_q, cand_d;

  logic                    fire, idle_go, cont, has_open;
  logic                    fl_en, nw_en;
  clsl_out_t               fl_res, nw_res;
  logic [KindBits-1:0]     word_kind, pair_kind;
  logic [7:0]              c;

  assign fire         = item_valid_i & room_i;
  assign item_ready_o = room_i;
  assign c            = item_i.char_code;

  // saturating counters
  assign line_inc = (line_q == '1) ? line_q : line_q + LineBits'(1);
  assign pos_inc  = (pos_q == '1) ? pos_q : pos_q + PositionBits'(1);
  assign len_inc  = (len_q == '1) ? len_q : len_q + PositionBits'(1);

  // keyword lookup on the open word, lowest keyword index wins
  always_comb begin
    word_kind = KindId;
    for (int k = KwCount - 1; k >= 0; k--) begin
      if (cand_q[k] && (len_q == PositionBits'(kw_len(KwIdxBits'(k))))) begin
        word_kind = KindBits'(k);
      end
    end
  end

  // pair kind of the held byte
  always_comb begin
    unique case (mode_q)
      ModeAmp:   pair_kind = KindAnd;
      ModeBar:   pair_kind = KindOr;
      ModePlus:  pair_kind = KindInc;
      default:   pair_kind = KindDec;
    endcase
  end

  assign has_open = (mode_q == ModeWord) || (mode_q == ModeNum) || (mode_q == ModeSlash) ||
                    (mode_q == ModeAmp) || (mode_q == ModeBar) || (mode_q == ModePlus) ||
                    (mode_q == ModeMinus);

  // result for the open or held token
  always_comb begin
    fl_res.token_kind   = (mode_q == ModeWord) ? word_kind :
                          (mode_q == ModeNum) ? KindNum : fkind_q;
    fl_res.token_line   = line_q;
    fl_res.token_start  = begin_q;
    fl_res.token_length = len_q;
    fl_res.token_char   = first_q;
    fl_res.last_of_run  = 1'b0;
  end

  // main scan step
  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    pos_d   = pos_inc;
    begin_d = begin_q;
    len_d   = len_q;
    first_d = first_q;
    fkind_d = fkind_q;
    cand_d  = cand_q;
    fl_en   = 1'b0;
    nw_en   = 1'b0;
    idle_go = 1'b0;
    cont    = 1'b0;
    nw_res.token_kind   = item_i.pkind;
    nw_res.token_line   = line_q;
    nw_res.token_start  = pos_q;
    nw_res.token_length = PositionBits'(1);
    nw_res.token_char   = c;
    nw_res.last_of_run  = 1'b1;

    if (item_i.end_of_text) begin
      // flush, end token, back to reset state
      fl_en               = has_open;
      nw_en               = 1'b1;
      nw_res.token_kind   = KindEnd;
      nw_res.token_length = '0;
      nw_res.token_char   = '0;
      mode_d              = ModeIdle;
      line_d              = LineBits'(1);
      pos_d               = '0;
      begin_d             = '0;
      len_d               = '0;
    end else begin
      unique case (mode_q)
        ModeWord, ModeNum: begin
          cont = (mode_q == ModeWord) ? (item_i.cls == ClsAlpha || item_i.cls == ClsDigit)
                                      : (item_i.cls == ClsDigit || item_i.cls == ClsDot);
          if (cont) begin
            if (len_q < PositionBits'(KwMaxLen)) begin
              for (int k = 0; k < KwCount; k++) begin
                cand_d[k] = cand_q[k] &&
                            (kw_char(KwIdxBits'(k), len_q[KwLenBits-1:0]) == c);
              end
            end
            len_d = len_inc;
          end else begin
            fl_en   = 1'b1;
            idle_go = 1'b1;
          end
        end
        ModeSlash: begin
          if (item_i.cls == ClsSlash) begin
            mode_d = ModeLineCom;
          end else if (item_i.cls == ClsStar) begin
            mode_d = ModeBlock;
          end else begin
            fl_en   = 1'b1;
            idle_go = 1'b1;
          end
        end
        ModeAmp, ModeBar, ModePlus, ModeMinus: begin
          if (c == first_q) begin
            nw_en               = 1'b1;
            nw_res.token_kind   = pair_kind;
            nw_res.token_start  = begin_q;
            nw_res.token_length = PositionBits'(2);
            mode_d              = ModeIdle;
          end else begin
            fl_en   = 1'b1;
            idle_go = 1'b1;
          end
        end
        ModeLineCom: begin
          if (item_i.cls == ClsNewline) begin
            line_d = line_inc;
            mode_d = ModeIdle;
          end
        end
        ModeBlock, ModeBlockStar: begin
          if (item_i.cls == ClsNewline) begin
            line_d = line_inc;
          end
          if (mode_q == ModeBlockStar && item_i.cls == ClsSlash) begin
            mode_d = ModeIdle;
          end else begin
            mode_d = (item_i.cls == ClsStar) ? ModeBlockStar : ModeBlock;
          end
        end
        default: idle_go = 1'b1;
      endcase

      // byte starts something new
      if (idle_go) begin
        mode_d = ModeIdle;
        unique case (item_i.cls)
          ClsNewline: line_d = line_inc;
          ClsSpace: ;
          ClsSlash, ClsAmp, ClsBar, ClsPlus, ClsMinus: begin
            unique case (item_i.cls)
              ClsSlash: mode_d = ModeSlash;
              ClsAmp:   mode_d = ModeAmp;
              ClsBar:   mode_d = ModeBar;
              ClsPlus:  mode_d = ModePlus;
              default:  mode_d = ModeMinus;
            endcase
            begin_d = pos_q;
            first_d = c;
            fkind_d = item_i.pkind;
            len_d   = PositionBits'(1);
          end
          ClsAlpha, ClsDigit: begin
            mode_d  = (item_i.cls == ClsAlpha) ? ModeWord : ModeNum;
            begin_d = pos_q;
            first_d = c;
            fkind_d = KindNum;
            len_d   = PositionBits'(1);
            for (int k = 0; k < KwCount; k++) begin
              cand_d[k] = (kw_char(KwIdxBits'(k), '0) == c);
            end
          end
          default: nw_en = 1'b1;
        endcase
      end
    end
  end

  // compact results into the output queue write
  always_comb begin
    push_o.en      = fire ? {fl_en & nw_en, fl_en | nw_en} : 2'b00;
    push_o.beat[0] = fl_en ? fl_res : nw_res;
    push_o.beat[0].last_of_run = ~(fl_en & nw_en);
    push_o.beat[1] = nw_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      line_q  <= LineBits'(1);
      pos_q   <= '0;
      begin_q <= '0;
      len_q   <= '0;
      first_q <= '0;
      fkind_q <= '0;
      cand_q  <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      len_q   <= len_d;
      first_q <= first_d;
      fkind_q <= fkind_d;
      cand_q  <= cand_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/clsl_outq.sv
// result queue: takes up to two beats a cycle, hands out one
`timescale 1ns / 1ps
`default_nettype none
module clsl_outq (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  clsl_pkg::clsl_push_t   push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output clsl_pkg::clsl_out_t    out_o
);
  import clsl_pkg::*;

  localparam int unsigned PtrW = $clog2(OutQDepth);
  localparam int unsigned CntW = $clog2(OutQDepth + 1);

  clsl_out_t         entry_q [OutQDepth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [CntW-1:0]   cnt_q, cnt_d, push_n;
  logic              pop;

  // room for a full double write, judged on the registered fill
  assign room_o      = (cnt_q <= CntW'(OutQDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = entry_q[rptr_q];
  assign pop         = out_valid_o & out_ready_i;
  assign push_n      = CntW'(push_i.en[0]) + CntW'(push_i.en[1]);
  assign wptr_nx     = wptr_q + PtrW'(1);

  // pointers and fill
  always_comb begin
    wptr_d = wptr_q + PtrW'(push_n);
    rptr_d = pop ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d  = cnt_q + push_n - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.en[0]) begin
      entry_q[wptr_q] <= push_i.beat[0];
    end
    if (push_i.en[1]) begin
      entry_q[wptr_nx] <= push_i.beat[1];
    end
  end

endmodule
`default_nettype wire

// File: rtl/c_like_source_lexer.sv
// top level of the streaming lexer for a small c-like language
`timescale 1ns / 1ps
`default_nettype none
`include "c_like_source_lexer_macros.svh"
// Takes one source byte per beat and sustains one byte per clock while the
// result queue has room. A byte is written into a two-entry classified-byte
// queue, the scanner takes it from there, and its results land in a four-entry
// result queue, from which the first result of a byte is offered on the output.
// A byte gives zero, one or two result beats; the scanner waits while the
// result queue holds more than two beats, which is what sets the rate when
// the output side stalls. The last beat caused by a byte carries last_of_run.
// An end of text beat flushes any open token, gives the end token and restarts
// line and offset counting.
module c_like_source_lexer (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  clsl_pkg::clsl_in_t     in_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output clsl_pkg::clsl_out_t    out_o
);
  import clsl_pkg::*;

  logic        item_valid, item_ready, room;
  clsl_item_t  item;
  clsl_push_t  push;

  // classify and queue
  clsl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // token scanner
  clsl_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .room_i       (room),
    .push_o       (push)
  );

  // result queue
  clsl_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // checks
  `CLSL_ASSERT_IMP(a_push_packed, clk_i, rst_ni, push.en[1], push.en[0], "second beat without first")
  `CLSL_ASSERT_IMP(a_push_room, clk_i, rst_ni, push.en != 2'b00, room, "write into full result queue")
  `CLSL_ASSERT_IMP(a_last_mark, clk_i, rst_ni, push.en == 2'b11,
                   push.beat[1].last_of_run && !push.beat[0].last_of_run, "last mark misplaced")
  `CLSL_ASSERT_NXT(a_push_shows, clk_i, rst_ni, push.en != 2'b00, out_valid_o, "written beat not shown")

endmodule
`default_nettype wire
